FILE: src/fpn_pkg.sv
// Shared types, constants and permutation table of the fractal noise generator.
package fpn_pkg;

  localparam int FPN_FRAC = 16;
  localparam int FPN_MAX_OCTAVES = 8;
  localparam int FPN_CELL_LAT = 11;

  localparam logic [3:0]  FPN_OCT_RST = 4'd4;
  localparam logic [23:0] FPN_INV_RST = 24'd3277;
  localparam logic [19:0] FPN_LAC_RST = 20'd131072;
  localparam logic [16:0] FPN_PER_RST = 17'd32768;

  localparam logic [43:0] FPN_ONE = 44'd1 << FPN_FRAC;
  localparam logic [47:0] FPN_FREQ_CAP = 48'hFFF_FFFF_FFFF;
  localparam logic [36:0] FPN_AMP_CAP = 37'h0F_FFFF_FFFF;
  localparam logic signed [41:0] FPN_SUM_MAX = 42'sd2097151;
  localparam logic signed [41:0] FPN_SUM_MIN = -42'sd2097152;

  typedef enum logic [1:0] {
    CFG_OCTAVES,
    CFG_INV_SCALE,
    CFG_LACUNARITY,
    CFG_PERSISTENCE
  } fpn_cfg_e;

  typedef struct packed {
    logic              vld;
    logic [33:0]       pc;
    logic [33:0]       pr;
    logic [33:0]       p1;
    logic [43:0]       freq;
    logic [35:0]       amp;
    logic signed [21:0] sum;
  } fpn_lane_t;

  localparam logic [7:0] FPN_PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

endpackage

FILE: src/fpn_cell.sv
// One octave cell: coordinates, hashing, fade, gradients, lerps and accumulation.
module fpn_cell import fpn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        active_i,
  input  logic [19:0] lac_i,
  input  logic [16:0] pers_i,
  input  fpn_lane_t   lane_i,
  output fpn_lane_t   lane_o
);

  function automatic logic signed [19:0] grad(input logic [3:0] h,
      input logic signed [17:0] x, input logic signed [17:0] y,
      input logic signed [17:0] z);
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic signed [19:0] su;
    logic signed [19:0] sv;
    u = h[3] ? y : x;
    priority if (h < 4'd4) v = y;
    else if (h == 4'd12 || h == 4'd14) v = x;
    else v = z;
    su = 20'(u);
    sv = 20'(v);
    if (h[0]) su = -su;
    if (h[1]) sv = -sv;
    return su + sv;
  endfunction

  function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
      input logic signed [19:0] b, input logic [16:0] w);
    logic signed [20:0] d;
    logic signed [38:0] p;
    d = 21'(b) - 21'(a);
    p = 39'(d) * $signed({22'b0, w});
    return a + 20'(p >>> 16);
  endfunction

  // lane carry, one entry per stage
  fpn_lane_t car_q [1:FPN_CELL_LAT];
  // lane entering stage 2 (next frequency) and the last stage (sum, amplitude)
  fpn_lane_t st2_d;
  fpn_lane_t lst_d;

  // stage 1
  logic [53:0] lo_q [3];
  logic [19:0] hi_q [3];
  logic [41:0] fql_q, fqh_q;
  // stage 2
  logic [7:0]  ci_q [3];
  logic [15:0] t2_q [3];
  logic [47:0] freq_n;
  // stage 3..6
  logic signed [38:0] tp_q [3];
  logic [15:0] t3_q [3], t4_q [3], t5_q [3];
  logic [35:0] m1_q [3], m2_q [3], m3_q [3];
  logic [7:0]  ha_q [2];
  logic [7:0]  hb_q [4];
  logic [7:0]  hh_q [8];
  logic [7:0]  yi3_q, zi3_q, zi4_q;
  logic signed [19:0] g_q [8];
  // stage 7..10
  logic signed [19:0] l1_q [4];
  logic signed [19:0] l2_q [2];
  logic signed [19:0] n_q;
  logic [16:0] fv_q, fw_q, fw8_q;
  logic signed [40:0] term_q;
  logic [34:0] al_q, ah_q;
  // stage 11
  logic signed [41:0] sum_x;
  logic signed [21:0] sum_n;
  logic [36:0] amp_x;
  logic [35:0] amp_n;

  logic [33:0] pos [3];
  assign pos[0] = lane_i.pc;
  assign pos[1] = lane_i.p1;
  assign pos[2] = lane_i.pr;

  always_comb begin
    logic [63:0] fx;
    fx = {fqh_q, 22'b0} + 64'(fql_q);
    freq_n = (fx[63:16] > FPN_FREQ_CAP) ? FPN_FREQ_CAP : fx[63:16];
  end

  always_comb begin
    logic [52:0] ax;
    sum_x = 42'(car_q[10].sum) + 42'(term_q);
    priority if (!active_i) sum_n = car_q[10].sum;
    else if (sum_x > FPN_SUM_MAX) sum_n = 22'(FPN_SUM_MAX);
    else if (sum_x < FPN_SUM_MIN) sum_n = 22'(FPN_SUM_MIN);
    else sum_n = 22'(sum_x);
    ax = {ah_q, 18'b0} + 53'(al_q);
    amp_x = ax[52:16];
    amp_n = (amp_x > FPN_AMP_CAP) ? 36'(FPN_AMP_CAP) : amp_x[35:0];
  end

  always_comb begin
    st2_d = car_q[1];
    st2_d.freq = freq_n[43:0];
    lst_d = car_q[FPN_CELL_LAT-1];
    lst_d.sum = sum_n;
    lst_d.amp = amp_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= FPN_CELL_LAT; s++) car_q[s] <= '0;
    end else if (en_i) begin
      car_q[1] <= lane_i;
      car_q[2] <= st2_d;
      for (int s = 3; s < FPN_CELL_LAT; s++) car_q[s] <= car_q[s-1];
      car_q[FPN_CELL_LAT] <= lst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // S1: coordinate partial products, low 40 bits only
      for (int c = 0; c < 3; c++) begin
        lo_q[c] <= 54'(pos[c]) * 54'(lane_i.freq[19:0]);
        hi_q[c] <= 20'(40'(pos[c][19:0]) * 40'(lane_i.freq[39:20]));
      end
      fql_q <= 42'(lane_i.freq[21:0]) * 42'(lac_i);
      fqh_q <= 42'(lane_i.freq[43:22]) * 42'(lac_i);
      // S2: wrapped Q8.16 coordinates
      for (int c = 0; c < 3; c++) begin
        logic [39:0] cs;
        cs = 40'(lo_q[c]) + {hi_q[c], 20'b0};
        ci_q[c] <= cs[39:32];
        t2_q[c] <= cs[31:16];
      end
      // S3..S6: fade, innermost product first
      for (int c = 0; c < 3; c++) begin
        logic signed [21:0] fp;
        logic signed [38:0] r1x;
        fp = $signed({6'b0, t2_q[c]}) * 22'sd6 - 22'sd983040;
        tp_q[c] <= 39'(fp) * $signed({23'b0, t2_q[c]});
        r1x = (tp_q[c] >>> 16) + 39'sd655360;
        m1_q[c] <= 36'(t3_q[c]) * 36'(r1x[19:0]);
        m2_q[c] <= 36'(t4_q[c]) * 36'(m1_q[c][35:16]);
        m3_q[c] <= 36'(t5_q[c]) * 36'(m2_q[c][35:16]);
        t3_q[c] <= t2_q[c];
        t4_q[c] <= t3_q[c];
        t5_q[c] <= t4_q[c];
      end
      // S3..S5: permutation hash chain
      ha_q[0] <= FPN_PERM[ci_q[0]];
      ha_q[1] <= FPN_PERM[8'(ci_q[0] + 8'd1)];
      yi3_q <= ci_q[1];
      zi3_q <= ci_q[2];
      for (int k = 0; k < 4; k++)
        hb_q[k] <= FPN_PERM[8'(ha_q[k%2] + yi3_q + 8'(k/2))];
      zi4_q <= zi3_q;
      for (int k = 0; k < 8; k++)
        hh_q[k] <= FPN_PERM[8'(hb_q[k%4] + zi4_q + 8'(k/4))];
      // S6: corner gradients, corner index {dz,dy,dx}
      for (int k = 0; k < 8; k++) begin
        logic signed [17:0] gx, gy, gz;
        gx = $signed({2'b0, t5_q[0]}) - ((k % 2) != 0 ? 18'sd65536 : 18'sd0);
        gy = $signed({2'b0, t5_q[1]}) - (((k / 2) % 2) != 0 ? 18'sd65536 : 18'sd0);
        gz = $signed({2'b0, t5_q[2]}) - ((k / 4) != 0 ? 18'sd65536 : 18'sd0);
        g_q[k] <= grad(hh_q[k][3:0], gx, gy, gz);
      end
      // S7..S9: trilinear blend
      for (int k = 0; k < 4; k++)
        l1_q[k] <= lerp(g_q[2*k], g_q[2*k+1], m3_q[0][32:16]);
      fv_q <= m3_q[1][32:16];
      fw_q <= m3_q[2][32:16];
      for (int k = 0; k < 2; k++)
        l2_q[k] <= lerp(l1_q[2*k], l1_q[2*k+1], fv_q);
      fw8_q <= fw_q;
      n_q <= lerp(l2_q[0], l2_q[1], fw8_q);
      // S10: weighted term and next amplitude partials
      begin
        logic signed [56:0] tm;
        tm = 57'(n_q) * $signed({21'b0, car_q[9].amp});
        term_q <= 41'(tm >>> 16);
      end
      al_q <= 35'(car_q[9].amp[17:0]) * 35'(pers_i);
      ah_q <= 35'(car_q[9].amp[35:18]) * 35'(pers_i);
    end
  end

  assign lane_o = car_q[FPN_CELL_LAT];

endmodule

FILE: src/fractal_perlin_noise_3d.sv
// Top level of the fractal 3D gradient noise generator.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one map position per transaction,
//    map_col_i as noise x and map_row_i as noise z (y is fixed at 1).
//  - Output channel (out_valid_o/out_ready_i): one saturated Q5.16 sum per
//    input transaction, in input order.
//  - Config channel (cfg_valid_i/cfg_ready_o): cfg_index_i selects octave
//    count, inv_scale, lacunarity or persistence; always ready. Write only
//    while no transaction is in flight.
//  - Throughput: one position per cycle unless stalled. Each octave is a
//    cell of 11 stages in a chain; a result passes the entry stage, every
//    octave cell and the output register in that order.
//    Unused octave cells pass the sum through, so latency does not depend
//    on the octave count.
//  - Stall: the whole chain holds while a result sits in the output register
//    and the receiver is not ready; input is not taken during that time.
//  - Reset: clears all valid flags and loads the default configuration.
module fractal_perlin_noise_3d import fpn_pkg::*; #(
  parameter int MAX_OCTAVES = FPN_MAX_OCTAVES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [9:0]         map_col_i,
  input  logic [9:0]         map_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [21:0] noise_sum_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam logic [4:0] MaxOct = 5'(MAX_OCTAVES);

  logic [3:0]  oct_q;
  logic [23:0] inv_q;
  logic [19:0] lac_q;
  logic [16:0] per_q;
  logic [4:0]  n_oct;

  logic en;
  fpn_lane_t s0_q;
  fpn_lane_t lane [0:MAX_OCTAVES];
  logic               out_vld_q;
  logic signed [21:0] out_sum_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q <= FPN_OCT_RST;
      inv_q <= FPN_INV_RST;
      lac_q <= FPN_LAC_RST;
      per_q <= FPN_PER_RST;
    end else if (cfg_valid_i) begin
      unique case (fpn_cfg_e'(cfg_index_i))
        CFG_OCTAVES:     oct_q <= cfg_data_i[3:0];
        CFG_INV_SCALE:   inv_q <= cfg_data_i;
        CFG_LACUNARITY:  lac_q <= cfg_data_i[19:0];
        CFG_PERSISTENCE: per_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // octave count clamps at the number of cells
  assign n_oct = (5'(oct_q) > MaxOct) ? MaxOct : 5'(oct_q);

  // single enable for the chain; holds only when the output is blocked
  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // entry stage: scale the position once, start at unit frequency/amplitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (en) begin
      s0_q.vld  <= in_valid_i;
      s0_q.pc   <= 34'(map_col_i) * 34'(inv_q);
      s0_q.pr   <= 34'(map_row_i) * 34'(inv_q);
      s0_q.p1   <= 34'(inv_q);
      s0_q.freq <= FPN_ONE;
      s0_q.amp  <= 36'(FPN_ONE);
      s0_q.sum  <= '0;
    end
  end

  assign lane[0] = s0_q;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fpn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (5'(k) < n_oct),
      .lac_i    (lac_q),
      .pers_i   (per_q),
      .lane_i   (lane[k]),
      .lane_o   (lane[k+1])
    );
  end

  // output register parts the chain from the receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_sum_q <= '0;
    end else if (en) begin
      out_vld_q <= lane[MAX_OCTAVES].vld;
      out_sum_q <= lane[MAX_OCTAVES].sum;
    end
  end

  assign out_valid_o = out_vld_q;
  assign noise_sum_o = out_sum_q;

  // no octaves summed means a zero result
  a_zero_oct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && oct_q == 4'd0) |-> noise_sum_o == 22'sd0)
    else $error("nonzero sum with zero octaves");

  // zero scale puts every sample on a lattice point, where noise is zero
  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inv_q == 24'd0) |-> noise_sum_o == 22'sd0)
    else $error("nonzero sum with zero scale");

endmodule
